>>> rtl/shbp_pkg.sv
package shbp_pkg;

  typedef enum logic [3:0] {
    PH_OUTER, PH_SOH, PH_RESP, PH_MODE, PH_TLVHDR, PH_BODY,
    PH_NSKIP, PH_NTYPE, PH_NFIX, PH_NVAR, PH_NSTOP, PH_DONE
  } phase_e;

  localparam logic [23:0] VENDOR_CODE = 24'h000137;
  localparam logic [15:0] MODE_LEN = 16'd34;
  localparam logic [7:0] COMP_HEALTH = 8'd128;

  localparam logic [3:0] K_NONE = 4'd0, K_OSVEN = 4'd1, K_OSVER = 4'd2, K_REL = 4'd3,
    K_BUILD = 4'd4, K_SPVER = 4'd5, K_SPREL = 4'd6, K_PROC = 4'd7, K_NAME = 4'd8,
    K_CORR = 4'd9, K_ROLE = 4'd10, K_HEALTH = 4'd11, K_OTHER = 4'd12;

  localparam logic [2:0] ST_OK = 3'd0, ST_NOVEN = 3'd1, ST_NORESP = 3'd2,
    ST_BADRESP = 3'd3, ST_BADMODE = 3'd4, ST_BADINNER = 3'd5, ST_TRUNC = 3'd6;

  localparam logic [15:0] TLV_HID = 16'd2, TLV_VEND = 16'd7, TLV_CLASS = 16'd8,
    TLV_STAT = 16'd11;

  // result record, packed for the output stage
  typedef struct packed {
    logic [2:0]  status;
    logic        done_res;
    logic [8:0]  health_component;
    logic [24:0] health_vendor;
    logic [1:0]  severity;
    logic [8:0]  health_class;
    logic [15:0] byte_position;
    logic [31:0] attribute_value;
    logic [3:0]  attribute_kind;
  } result_t;

  function automatic logic [7:0] fixed_len(input logic [7:0] t);
    case (t)
      8'd1: fixed_len = 8'd18;
      8'd2: fixed_len = 8'd12;
      8'd3: fixed_len = 8'd1;
      8'd4: fixed_len = 8'd2;
      8'd5: fixed_len = 8'd2;
      8'd6: fixed_len = 8'd24;
      8'd7: fixed_len = 8'd2;
      8'd8: fixed_len = 8'd5;
      default: fixed_len = 8'd0;
    endcase
  endfunction

  function automatic logic [1:0] grade(input logic [8:0] cls, input logic [31:0] w);
    if (cls == 9'd4) begin
      case (w)
        32'h00ff0005: grade = 2'd0;
        32'h00ff0006, 32'h00ff0008, 32'hc0ff000e, 32'hc0ff0010: grade = 2'd1;
        default: grade = 2'd2;
      endcase
    end else if (cls == 9'd3) begin
      case (w)
        32'd2, 32'd3, 32'd4: grade = 2'd0;
        32'd1, 32'd5, 32'hc0ff0003, 32'hc0ff0018: grade = 2'd1;
        default: grade = 2'd2;
      endcase
    end else if (cls <= 9'd2) begin
      grade = (w[31:24] != 8'd0) ? 2'd2 : 2'd0;
    end else begin
      grade = 2'd3;
    end
  endfunction

endpackage

>>> rtl/shbp_core.sv
module shbp_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              b_i,
  input  logic                    last_i,
  input  logic [23:0]             vendor_i,
  output logic                    have_o,
  output shbp_pkg::result_t       res_o
);
  import shbp_pkg::*;

  phase_e      ph_q, ph_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] inner_q, inner_d, ttype_q, ttype_d, trem_q, trem_d, nrem_q, nrem_d;
  logic [7:0]  nrt_q, nrt_d;
  logic [24:0] cv_q, cv_d;
  logic [8:0]  cc_q, cc_d, cls_q, cls_d;
  logic [2:0]  err_q, err_d;

  logic [31:0] acc;
  logic [5:0]  i;
  logic        ms, emit;
  logic [3:0]  kind;
  logic [31:0] val;
  logic [15:0] pos, rem, t16;
  logic [1:0]  sev;
  logic [2:0]  st;

  always_comb begin
    i = cnt_q;
    acc = {acc_q[23:0], b_i};
    ms = (cv_q == {1'b0, vendor_i});
    ph_d = ph_q; cnt_d = (i < 6'd63) ? i + 6'd1 : 6'd63; acc_d = acc_q;
    inner_d = inner_q; ttype_d = ttype_q; trem_d = trem_q; nrem_d = nrem_q;
    nrt_d = nrt_q; cv_d = cv_q; cc_d = cc_q; cls_d = cls_q; err_d = err_q;
    emit = 1'b0; kind = K_NONE; val = '0; pos = '0; sev = '0;
    rem = '0; t16 = acc[15:0];
    case (ph_q)
      PH_OUTER: begin
        acc_d = acc;
        if (i == 6'd1 && t16 != 16'd7) ttype_d = 16'd1;
        if (i == 6'd7) begin
          if (acc != {8'd0, vendor_i} || ttype_q != 16'd0) begin
            err_d = ST_NOVEN; ph_d = PH_DONE;
          end else ph_d = PH_SOH;
          cnt_d = '0; acc_d = '0; ttype_d = '0;
        end
      end
      PH_SOH: begin
        acc_d = acc;
        if (i == 6'd1 && t16 != 16'd1) ttype_d = 16'd1;
        if (i == 6'd3) begin
          if (ttype_q != 16'd0) begin err_d = ST_NORESP; ph_d = PH_DONE; end
          else ph_d = PH_RESP;
          cnt_d = '0; acc_d = '0; ttype_d = '0;
        end
      end
      PH_RESP, PH_MODE: begin
        acc_d = acc;
        if (i == 6'd1 && t16 != 16'd7) ttype_d = 16'd1;
        if (i == 6'd7 && acc != {8'd0, vendor_i}) ttype_d = 16'd1;
        if (ph_q == PH_RESP) begin
          if (i == 6'd9) nrt_d = (t16 == 16'd1) ? 8'd1 : (t16 == 16'd2) ? 8'd2 : 8'd0;
          if (i == 6'd11) begin
            inner_d = t16; cnt_d = '0; acc_d = '0; ttype_d = '0;
            if (ttype_q != 16'd0) begin err_d = ST_BADRESP; ph_d = PH_DONE; end
            else if (nrt_q == 8'd0) begin err_d = ST_BADINNER; ph_d = PH_DONE; end
            else if (nrt_q == 8'd1) ph_d = (t16 >= 16'd4) ? PH_TLVHDR : PH_DONE;
            else ph_d = PH_MODE;
          end
        end else if (i == 6'd33) begin
          cnt_d = '0; acc_d = '0; ttype_d = '0;
          if (ttype_q != 16'd0 || b_i != 8'd0) begin
            err_d = ST_BADMODE; ph_d = PH_DONE;
          end else begin
            inner_d = (inner_q >= MODE_LEN) ? inner_q - MODE_LEN : 16'd0;
            ph_d = (inner_d >= 16'd4) ? PH_TLVHDR : PH_DONE;
          end
        end
      end
      PH_TLVHDR: begin
        acc_d = acc;
        if (inner_q != 16'd0) inner_d = inner_q - 16'd1;
        if (i == 6'd1) ttype_d = t16;
        if (i == 6'd3) begin
          trem_d = t16; cnt_d = '0; acc_d = '0;
          if (ttype_q == TLV_STAT && !(ms && cc_q == {1'b0, COMP_HEALTH})) begin
            emit = 1'b1; kind = K_OTHER;
          end
          if (t16 == 16'd0) ph_d = (inner_d >= 16'd4) ? PH_TLVHDR : PH_DONE;
          else if (ttype_q == TLV_VEND && ms && cc_q == 9'd0 && t16 > 16'd4)
            ph_d = PH_NSKIP;
          else ph_d = PH_BODY;
        end
      end
      PH_BODY, PH_NSKIP, PH_NTYPE, PH_NFIX, PH_NVAR, PH_NSTOP: begin
        if (trem_q != 16'd0) trem_d = trem_q - 16'd1;
        if (inner_q != 16'd0) inner_d = inner_q - 16'd1;
        rem = trem_d;
        case (ph_q)
          PH_BODY: begin
            acc_d = acc;
            if (ttype_q == TLV_HID && i == 6'd3) begin
              cv_d = {1'b0, acc[31:8]}; cc_d = {1'b0, acc[7:0]};
            end
            if (ttype_q == TLV_CLASS && i == 6'd0) cls_d = {1'b0, b_i};
            if (ttype_q == TLV_STAT && ms && cc_q == {1'b0, COMP_HEALTH} && i == 6'd3) begin
              emit = 1'b1; kind = K_HEALTH; val = acc; sev = grade(cls_q, acc);
            end
          end
          PH_NSKIP:
            if (i == 6'd3) begin ph_d = PH_NTYPE; cnt_d = '0; acc_d = '0; end
          PH_NTYPE: begin
            cnt_d = '0; acc_d = '0;
            if (b_i >= 8'd1 && b_i <= 8'd8 && rem >= {8'd0, fixed_len(b_i)}) begin
              nrt_d = b_i; ph_d = PH_NFIX;
              if (b_i == 8'd1) begin emit = 1'b1; kind = K_OSVEN; val = {8'd0, VENDOR_CODE}; end
            end else ph_d = PH_NSTOP;
          end
          PH_NFIX: begin
            acc_d = acc;
            case (nrt_q)
              8'd1: begin
                if (i == 6'd3) begin emit = 1'b1; kind = K_OSVER; val = acc; end
                else if (i == 6'd7) begin emit = 1'b1; kind = K_REL; val = acc; end
                else if (i == 6'd11) begin emit = 1'b1; kind = K_BUILD; val = acc; end
                else if (i == 6'd13) begin emit = 1'b1; kind = K_SPVER; val = {16'd0, t16}; end
                else if (i == 6'd15) begin emit = 1'b1; kind = K_SPREL; val = {16'd0, t16}; end
                else if (i == 6'd17) begin
                  emit = 1'b1; kind = K_PROC; val = {16'd0, t16};
                  ph_d = PH_NTYPE; cnt_d = '0; acc_d = '0;
                end
              end
              8'd2, 8'd4, 8'd5, 8'd7: begin
                if ((nrt_q == 8'd2 && i == 6'd11) || (nrt_q != 8'd2 && i == 6'd1)) begin
                  cnt_d = '0; acc_d = '0;
                  if (t16 == 16'd0) ph_d = PH_NTYPE;
                  else if (t16 > rem) ph_d = PH_NSTOP;
                  else begin ph_d = PH_NVAR; nrem_d = t16; end
                end
              end
              8'd3: begin ph_d = PH_NTYPE; cnt_d = '0; acc_d = '0; end
              8'd6: begin
                emit = 1'b1; kind = K_CORR; val = {24'd0, b_i}; pos = {10'd0, i};
                if (i == 6'd23) begin ph_d = PH_NTYPE; cnt_d = '0; acc_d = '0; end
              end
              8'd8:
                if (i == 6'd4) begin
                  emit = 1'b1; kind = K_ROLE; val = {24'd0, b_i};
                  ph_d = PH_NTYPE; cnt_d = '0; acc_d = '0;
                end
              default: begin ph_d = PH_NSTOP; cnt_d = '0; acc_d = '0; end
            endcase
          end
          PH_NVAR: begin
            if (nrt_q == 8'd5) begin
              emit = 1'b1; kind = K_NAME; val = {24'd0, b_i}; pos = acc_q[15:0];
            end
            acc_d = {16'd0, acc_q[15:0] + 16'd1};
            if (nrem_q != 16'd0) nrem_d = nrem_q - 16'd1;
            if (nrem_d == 16'd0) begin ph_d = PH_NTYPE; cnt_d = '0; acc_d = '0; end
          end
          default: ;
        endcase
        if (trem_d == 16'd0) begin
          ph_d = (inner_d >= 16'd4) ? PH_TLVHDR : PH_DONE; cnt_d = '0; acc_d = '0;
        end
      end
      default: begin ph_d = PH_DONE; cnt_d = '0; acc_d = '0; end
    endcase
    st = (err_d != ST_OK) ? err_d : ((ph_d == PH_DONE) ? ST_OK : ST_TRUNC);
    have_o = emit || last_i;
    res_o.attribute_kind = kind;
    res_o.attribute_value = val;
    res_o.byte_position = pos;
    res_o.health_class = cls_d;
    res_o.severity = sev;
    res_o.health_vendor = cv_d;
    res_o.health_component = cc_d;
    res_o.done_res = last_i;
    res_o.status = last_i ? st : ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_OUTER; cnt_q <= '0; acc_q <= '0; inner_q <= '0; ttype_q <= '0;
      trem_q <= '0; nrem_q <= '0; nrt_q <= '0; err_q <= '0;
      cv_q <= '1; cc_q <= '1; cls_q <= '1;
    end else if (step_i) begin
      if (last_i) begin
        ph_q <= PH_OUTER; cnt_q <= '0; acc_q <= '0; inner_q <= '0; ttype_q <= '0;
        trem_q <= '0; nrem_q <= '0; nrt_q <= '0; err_q <= '0;
        cv_q <= '1; cc_q <= '1; cls_q <= '1;
      end else begin
        ph_q <= ph_d; cnt_q <= cnt_d; acc_q <= acc_d; inner_q <= inner_d;
        ttype_q <= ttype_d; trem_q <= trem_d; nrem_q <= nrem_d; nrt_q <= nrt_d;
        err_q <= err_d; cv_q <= cv_d; cc_q <= cc_d; cls_q <= cls_d;
      end
    end
  end
endmodule

>>> rtl/shbp_out.sv
module shbp_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  shbp_pkg::result_t res_i,
  output logic              full_o,
  input  logic              rd_i,
  output shbp_pkg::result_t res_o
);
  import shbp_pkg::*;

  logic    full_q;
  result_t res_q;

  assign full_o = full_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (wr_i) full_q <= 1'b1;
    else if (rd_i) full_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) res_q <= res_i;
  end
endmodule

>>> rtl/soh_health_blob_parser.sv
// a byte is registered in the input stage, and its result is then registered in the output register
// throughput: one byte per cycle unless stalled; the input register refills while the output is drained
// a byte waits in the input stage only while the output register holds an untaken result
// reset: async active low, parser at the outer header, ids and class invalid, vendor 0x137
module soh_health_blob_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // attribute_value, byte_position, health_class, severity,
  // health_vendor, health_component, status
  output logic [95:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // attribute_kind
  output logic        m_axis_tlast_o    // done_res
);
  import shbp_pkg::*;

  logic [23:0] vendor_q;
  logic        in_v_q, in_last_q;
  logic [7:0]  in_b_q;
  logic        have, full, step, wr;
  result_t     res, ores;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vendor_q <= VENDOR_CODE;
    else if (cfg_valid_i && cfg_ready_o) vendor_q <= cfg_data_i;
  end

  // input stage moves on when the output register can take its result
  assign step = in_v_q && (!have || !full || m_axis_tready_i);
  assign wr = step && have;
  assign s_axis_tready_o = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else if (s_axis_tready_o) in_v_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_b_q <= s_axis_tdata_i; in_last_q <= s_axis_tlast_i;
    end
  end

  shbp_core u_core (
    .clk_i, .rst_ni, .step_i(step), .b_i(in_b_q), .last_i(in_last_q),
    .vendor_i(vendor_q), .have_o(have), .res_o(res)
  );

  shbp_out u_out (
    .clk_i, .rst_ni, .wr_i(wr), .res_i(res), .full_o(full),
    .rd_i(m_axis_tready_i), .res_o(ores)
  );

  assign m_axis_tvalid_o = full;
  assign m_axis_tlast_o = ores.done_res;
  assign m_axis_tuser_o = ores.attribute_kind;
  assign m_axis_tdata_o = {ores.status, ores.health_component, ores.health_vendor,
                           ores.severity, ores.health_class, ores.byte_position,
                           ores.attribute_value};
endmodule

>>> rtl/shbp_checker.sv
module shbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import shbp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
      $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[95:93] == ST_OK)
    else $error("status outside done result");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= K_OTHER)
    else $error("bad kind");
  a_sev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != K_HEALTH |-> m_axis_tdata_o[58:57] == 2'd0)
    else $error("severity without health status");
endmodule

bind soh_health_blob_parser shbp_checker u_chk (.*);
